// ----- hw/rtl/nonpreemptive_priority_scheduler_assert.svh -----
// Assertion macros for the priority scheduler checker.
// Standalone header; included by the checker file only.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NPPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NPPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/npps_pkg.sv -----
// Shared types and constants for the non-preemptive priority scheduler.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package npps_pkg;

    localparam int MAX_PROCS_DEF = 32;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 22;
    localparam int SUM_W   = 27;
    localparam int PNUM_W  = 6;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    // Input beat: arrival, burst, priority from the lowest bit up.
    localparam int S_DATA_W = ARR_W + BURST_W + PRIO_W;

    // Result beat field offsets.
    localparam int PNUM_LSB = 0;
    localparam int COMP_LSB = PNUM_LSB + PNUM_W;
    localparam int TURN_LSB = COMP_LSB + TIME_W;
    localparam int WAIT_LSB = TURN_LSB + TIME_W;
    localparam int SUMW_LSB = WAIT_LSB + TIME_W;
    localparam int SUMT_LSB = SUMW_LSB + SUM_W;
    localparam int M_USED_W = SUMT_LSB + SUM_W;
    localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;

    // One process record as held in a ring cell.
    typedef struct packed {
        logic               valid;
        logic               done;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  comp;
    } rec_t;

    typedef struct packed {
        logic scan_en;
        logic pass_last;
        logic clear;
    } pick_ctl_t;

    typedef struct packed {
        logic emit_en;
        logic is_last;
    } rpt_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

// ----- hw/rtl/npps_cell.sv -----
// One ring cell: holds a single process record and passes it to its neighbor.
// Depends on npps_pkg.
`timescale 1ns / 1ps

module npps_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           clear,
    input  logic           load_en,
    input  logic           shift_en,
    input  npps_pkg::rec_t load_rec,
    input  npps_pkg::rec_t shift_rec,
    output npps_pkg::rec_t rec
);

    logic valid_reg;
    logic done_reg;
    logic [npps_pkg::ARR_W-1:0]   arrival_reg;
    logic [npps_pkg::BURST_W-1:0] burst_reg;
    logic [npps_pkg::PRIO_W-1:0]  prio_reg;
    logic [npps_pkg::TIME_W-1:0]  comp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else if (load_en) begin
            valid_reg <= 1'b1;
            done_reg  <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= shift_rec.valid;
            done_reg  <= shift_rec.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            arrival_reg <= load_rec.arrival;
            burst_reg   <= load_rec.burst;
            prio_reg    <= load_rec.prio;
            comp_reg    <= load_rec.comp;
        end else if (shift_en) begin
            arrival_reg <= shift_rec.arrival;
            burst_reg   <= shift_rec.burst;
            prio_reg    <= shift_rec.prio;
            comp_reg    <= shift_rec.comp;
        end
    end

    assign rec = '{valid: valid_reg, done: done_reg, arrival: arrival_reg,
                   burst: burst_reg, prio: prio_reg, comp: comp_reg};

endmodule

// ----- hw/rtl/npps_pick.sv -----
// Head unit of the ring: applies the last pick's completion and scans for the next one.
// Depends on npps_pkg.
`timescale 1ns / 1ps

module npps_pick #(
    parameter int MAX_PROCS = npps_pkg::MAX_PROCS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  npps_pkg::pick_ctl_t   ctl,
    input  logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] pos,
    input  npps_pkg::rec_t        head,
    output npps_pkg::rec_t        fixed,
    output logic                  picked
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int TIME_W = npps_pkg::TIME_W;

    logic [TIME_W-1:0] clock_reg;
    logic found_reg;
    logic any_reg;
    logic [npps_pkg::PRIO_W-1:0]  bprio_reg;
    logic [npps_pkg::ARR_W-1:0]   barr_reg;
    logic [npps_pkg::BURST_W-1:0] bburst_reg;
    logic [IDX_W-1:0]             bpos_reg;
    logic [npps_pkg::ARR_W-1:0]   min_reg;
    logic             upd_valid_reg;
    logic [IDX_W-1:0] upd_pos_reg;
    logic [TIME_W-1:0] upd_comp_reg;

    logic eligible, take, unfin, mtake, nfound, nany;
    logic [npps_pkg::PRIO_W-1:0]  nprio;
    logic [npps_pkg::ARR_W-1:0]   narr;
    logic [npps_pkg::BURST_W-1:0] nburst;
    logic [IDX_W-1:0]             npos;
    logic [npps_pkg::ARR_W-1:0]   nmin;
    logic [TIME_W:0]   run_sum;
    logic [TIME_W-1:0] run_end;

    // Mark the previous pick done as it passes the head.
    always_comb begin
        fixed = head;
        if (upd_valid_reg && (pos == upd_pos_reg)) begin
            fixed.done = 1'b1;
            fixed.comp = upd_comp_reg;
        end
    end

    always_comb begin
        eligible = fixed.valid && !fixed.done && (TIME_W'(fixed.arrival) <= clock_reg);
        take = eligible && (!found_reg || (fixed.prio < bprio_reg) ||
               ((fixed.prio == bprio_reg) && (fixed.arrival < barr_reg)));
        nfound = found_reg || take;
        nprio  = take ? fixed.prio    : bprio_reg;
        narr   = take ? fixed.arrival : barr_reg;
        nburst = take ? fixed.burst   : bburst_reg;
        npos   = take ? pos           : bpos_reg;

        unfin = fixed.valid && !fixed.done;
        mtake = unfin && (!any_reg || (fixed.arrival < min_reg));
        nany  = any_reg || mtake;
        nmin  = mtake ? fixed.arrival : min_reg;

        run_sum = {1'b0, clock_reg} + (TIME_W+1)'(nburst);
        run_end = run_sum[TIME_W] ? npps_pkg::TIME_MAX : run_sum[TIME_W-1:0];
    end

    assign picked = ctl.scan_en && ctl.pass_last && nfound;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            clock_reg     <= '0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
            upd_valid_reg <= 1'b0;
        end else if (ctl.scan_en) begin
            if (ctl.pass_last) begin
                found_reg <= 1'b0;
                any_reg   <= 1'b0;
                if (nfound) begin
                    clock_reg     <= run_end;
                    upd_valid_reg <= 1'b1;
                end else begin
                    // Idle gap: jump to the earliest pending arrival.
                    clock_reg <= TIME_W'(nmin);
                end
            end else begin
                found_reg <= nfound;
                any_reg   <= nany;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.scan_en) begin
            bprio_reg  <= nprio;
            barr_reg   <= narr;
            bburst_reg <= nburst;
            bpos_reg   <= npos;
            min_reg    <= nmin;
            if (ctl.pass_last && nfound) begin
                upd_pos_reg  <= npos;
                upd_comp_reg <= run_end;
            end
        end
    end

endmodule

// ----- hw/rtl/npps_report.sv -----
// Result stage: turnaround, waiting and running sums, held in the output register.
// Depends on npps_pkg.
`timescale 1ns / 1ps

module npps_report #(
    parameter int MAX_PROCS = npps_pkg::MAX_PROCS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  npps_pkg::rpt_ctl_t   ctl,
    input  logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] pos,
    input  npps_pkg::rec_t       rec,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [npps_pkg::M_DATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int TIME_W = npps_pkg::TIME_W;
    localparam int SUM_W  = npps_pkg::SUM_W;

    logic m_tvalid_reg;
    logic m_tlast_reg;
    logic [npps_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic [SUM_W-1:0] sumw_reg, sumt_reg;

    logic [TIME_W-1:0] turn, wait_t, burst_x;
    logic [SUM_W:0]    sw_raw, st_raw;
    logic [SUM_W-1:0]  sw_sat, st_sat;
    logic [npps_pkg::PNUM_W-1:0] pnum;
    logic [npps_pkg::M_DATA_W-1:0] m_tdata_next;

    always_comb begin
        burst_x = TIME_W'(rec.burst);
        turn    = rec.comp - TIME_W'(rec.arrival);
        wait_t  = (turn >= burst_x) ? (turn - burst_x) : '0;
        sw_raw  = {1'b0, sumw_reg} + (SUM_W+1)'(wait_t);
        st_raw  = {1'b0, sumt_reg} + (SUM_W+1)'(turn);
        sw_sat  = sw_raw[SUM_W] ? npps_pkg::SUM_MAX : sw_raw[SUM_W-1:0];
        st_sat  = st_raw[SUM_W] ? npps_pkg::SUM_MAX : st_raw[SUM_W-1:0];
        pnum    = npps_pkg::PNUM_W'({1'b0, pos} + 1'b1);

        m_tdata_next = '0;
        m_tdata_next[npps_pkg::PNUM_LSB +: npps_pkg::PNUM_W] = pnum;
        m_tdata_next[npps_pkg::COMP_LSB +: TIME_W] = rec.comp;
        m_tdata_next[npps_pkg::TURN_LSB +: TIME_W] = turn;
        m_tdata_next[npps_pkg::WAIT_LSB +: TIME_W] = wait_t;
        m_tdata_next[npps_pkg::SUMW_LSB +: SUM_W]  = ctl.is_last ? sw_sat : '0;
        m_tdata_next[npps_pkg::SUMT_LSB +: SUM_W]  = ctl.is_last ? st_sat : '0;
    end

    assign free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            sumw_reg     <= '0;
            sumt_reg     <= '0;
        end else if (ctl.emit_en) begin
            m_tvalid_reg <= 1'b1;
            sumw_reg     <= ctl.is_last ? '0 : sw_sat;
            sumt_reg     <= ctl.is_last ? '0 : st_sat;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit_en) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= ctl.is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- hw/rtl/nonpreemptive_priority_scheduler.sv -----
// Non-preemptive priority scheduler. Load one process per input beat (arrival, burst,
// priority); the beat with tlast set, or the one that fills all MAX_PROCS slots, starts
// the schedule. Processes sit in a ring of MAX_PROCS cells; while scanning it rotates
// one place per cycle past a single compare unit at its head, so every scan pass sees
// each cell once. Each pass picks the arrived, unfinished process with the lowest
// priority value (ties: earlier arrival, then lower load position) and runs it to the
// end; a pass that finds nothing arrived moves the clock to the earliest pending arrival
// and is followed by another pass. A run of N processes therefore takes N to 2N passes.
// Results come out in load order, one beat per process, with the waiting and
// turnaround sums on the tlast beat only. The input is not ready from the start of
// scheduling until the final result is in the output register; it is ready again while
// that beat waits. Times saturate at 2^22-1, sums at 2^27-1.
// Depends on npps_pkg, npps_cell, npps_pick and npps_report.
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler #(
    parameter int MAX_PROCS = npps_pkg::MAX_PROCS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // arrival_time [15:0], burst_time [31:16], prio_level [39:32]
    input  logic [npps_pkg::S_DATA_W-1:0] s_tdata,
    input  logic s_tlast,
    input  logic s_tvalid,
    output logic s_tready,
    // process_number [5:0], completion_time [27:6], turnaround_time [49:28],
    // waiting_time [71:50], sum_waiting [98:72], sum_turnaround [125:99], zero fill
    output logic [npps_pkg::M_DATA_W-1:0] m_tdata,
    output logic m_tlast,
    output logic m_tvalid,
    input  logic m_tready
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    npps_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] finished_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;

    logic load_acc, load_start, pass_last, is_last, rpt_free, picked;
    logic scan_en, emit_en, run_clear, shift_en;
    logic [CNT_W-1:0] count_inc;

    npps_pkg::rec_t cell_rec [MAX_PROCS];
    npps_pkg::rec_t load_rec;
    npps_pkg::rec_t fixed;
    npps_pkg::pick_ctl_t pick_ctl;
    npps_pkg::rpt_ctl_t  rpt_ctl;

    // ------------------------------------------------------------------
    // Handshake and sequencing conditions
    // ------------------------------------------------------------------
    assign load_acc   = s_tvalid && s_tready;
    assign count_inc  = count_reg + CNT_W'(1);
    assign load_start = s_tlast || (count_inc == CNT_W'(MAX_PROCS));
    assign pass_last  = (pos_reg == IDX_W'(MAX_PROCS - 1));
    assign is_last    = ((CNT_W'(pos_reg) + CNT_W'(1)) == count_reg);
    assign pos_next   = pass_last ? '0 : pos_reg + IDX_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            npps_pkg::ST_LOAD: begin
                if (s_tvalid && load_start) state_next = npps_pkg::ST_SCAN;
            end
            npps_pkg::ST_SCAN: begin
                // Last pick of the run: results follow.
                if (picked && ((finished_reg + CNT_W'(1)) == count_reg)) begin
                    state_next = npps_pkg::ST_EMIT;
                end
            end
            npps_pkg::ST_EMIT: begin
                if (rpt_free && is_last) state_next = npps_pkg::ST_LOAD;
            end
            default: state_next = npps_pkg::ST_LOAD;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready = 1'b0;
        scan_en  = 1'b0;
        emit_en  = 1'b0;
        unique case (state_reg)
            npps_pkg::ST_LOAD: s_tready = 1'b1;
            npps_pkg::ST_SCAN: scan_en  = 1'b1;
            npps_pkg::ST_EMIT: emit_en  = rpt_free;
            default: ;
        endcase
    end

    // Drop the whole run once its final result is in the output register.
    assign run_clear = emit_en && is_last;
    assign shift_en  = scan_en || emit_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= npps_pkg::ST_LOAD;
            count_reg    <= '0;
            finished_reg <= '0;
            pos_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (run_clear) begin
                count_reg    <= '0;
                finished_reg <= '0;
                pos_reg      <= '0;
            end else begin
                if (load_acc) count_reg <= count_inc;
                if (picked) finished_reg <= finished_reg + CNT_W'(1);
                if (shift_en) pos_reg <= pos_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ring of process cells; cell 0 is the head, the head unit feeds the tail
    // ------------------------------------------------------------------
    assign load_rec = '{valid: 1'b1, done: 1'b0,
                        arrival: s_tdata[npps_pkg::ARR_W-1:0],
                        burst: s_tdata[npps_pkg::ARR_W +: npps_pkg::BURST_W],
                        prio: s_tdata[npps_pkg::ARR_W + npps_pkg::BURST_W +: npps_pkg::PRIO_W],
                        comp: '0};

    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        npps_pkg::rec_t shift_in;
        if (i == MAX_PROCS - 1) begin : g_tail
            assign shift_in = fixed;
        end else begin : g_body
            assign shift_in = cell_rec[i+1];
        end

        npps_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (run_clear),
            .load_en   (load_acc && (count_reg == CNT_W'(i))),
            .shift_en  (shift_en),
            .load_rec  (load_rec),
            .shift_rec (shift_in),
            .rec       (cell_rec[i])
        );
    end

    // ------------------------------------------------------------------
    // Head compare unit and result stage
    // ------------------------------------------------------------------
    assign pick_ctl = '{scan_en: scan_en, pass_last: pass_last, clear: run_clear};

    npps_pick #(
        .MAX_PROCS (MAX_PROCS)
    ) u_pick (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (pick_ctl),
        .pos     (pos_reg),
        .head    (cell_rec[0]),
        .fixed   (fixed),
        .picked  (picked)
    );

    assign rpt_ctl = '{emit_en: emit_en, is_last: is_last};

    npps_report #(
        .MAX_PROCS (MAX_PROCS)
    ) u_report (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (rpt_ctl),
        .pos      (pos_reg),
        .rec      (fixed),
        .free     (rpt_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hw/rtl/npps_checker.sv -----
// Port-level checks for the priority scheduler, bound to the top level.
// Depends on npps_pkg and nonpreemptive_priority_scheduler_assert.svh.
`timescale 1ns / 1ps

`include "nonpreemptive_priority_scheduler_assert.svh"

module npps_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tlast,
    input logic s_tvalid,
    input logic s_tready,
    input logic [npps_pkg::M_DATA_W-1:0] m_tdata,
    input logic m_tlast,
    input logic m_tvalid,
    input logic m_tready
);

    localparam int TW = npps_pkg::TIME_W;

    logic [TW-1:0] comp_f, turn_f, wait_f;
    logic sums_zero;

    assign comp_f = m_tdata[npps_pkg::COMP_LSB +: TW];
    assign turn_f = m_tdata[npps_pkg::TURN_LSB +: TW];
    assign wait_f = m_tdata[npps_pkg::WAIT_LSB +: TW];
    assign sums_zero = (m_tdata[npps_pkg::SUMW_LSB +: 2*npps_pkg::SUM_W] == '0);

    `NPPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")
    `NPPS_ASSERT_NEXT(a_start_blocks_in, s_tvalid && s_tready && s_tlast, !s_tready, "input still ready after the closing load beat")
    `NPPS_ASSERT_NOW(a_busy_while_emitting, m_tvalid && !m_tlast, !s_tready, "input ready while a run is still reporting")
    `NPPS_ASSERT_NOW(a_sums_only_last, m_tvalid && !m_tlast, sums_zero, "sums nonzero on a non-final result")
    `NPPS_ASSERT_NOW(a_time_order, m_tvalid, (wait_f <= turn_f) && (turn_f <= comp_f), "waiting, turnaround and completion out of order")

endmodule

bind nonpreemptive_priority_scheduler npps_checker u_npps_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking bench for the non-preemptive priority scheduler.
// Depends on npps_pkg and nonpreemptive_priority_scheduler; reads no files.
`timescale 1ns / 1ps

module tb;
    import npps_pkg::*;

    localparam int MAX_JOBS    = MAX_PROCS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_JOBS = 80;

    // One expected result beat, fields as they appear on m_tdata plus tlast.
    typedef struct packed {
        logic [PNUM_W-1:0] pnum;
        logic [TIME_W-1:0] comp;
        logic [TIME_W-1:0] turn;
        logic [TIME_W-1:0] waiting;
        logic [SUM_W-1:0]  sum_wait;
        logic [SUM_W-1:0]  sum_turn;
        logic              last;
    } sched_report_t;

    // Directed row: one process. Rows with typed set are single-process sets whose
    // result is written out here; all other rows go through the predictor.
    typedef struct {
        int arrival;
        int burst;
        int prio;
        bit last;
        bit typed;
        int comp;
        int turn;
        int waiting;
        int sum_wait;
        int sum_turn;
    } stim_row_t;

    localparam int NUM_ROWS = 17;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // zero burst, lone process at time zero
        '{0, 0, 0, 1'b1, 1'b1, 0, 0, 0, 0, 0},
        // all fields at their top, clock jumps to the arrival first
        '{65535, 65535, 255, 1'b1, 1'b1, 131070, 65535, 0, 0, 65535},
        // full tie on priority and arrival: lower load position first
        '{5, 3, 7, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{5, 2, 7, 1'b1, 1'b0, 0, 0, 0, 0, 0},
        // priority tie broken by the earlier arrival
        '{10, 4, 3, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{2, 1, 3, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{0, 50, 9, 1'b1, 1'b0, 0, 0, 0, 0, 0},
        // nothing arrived: clock jumps between arrivals
        '{100, 1, 1, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{300, 2, 0, 1'b1, 1'b0, 0, 0, 0, 0, 0},
        // strict priority order among processes that arrive while one runs
        '{0, 10, 200, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{1, 5, 100, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{2, 5, 50, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{3, 1, 0, 1'b1, 1'b0, 0, 0, 0, 0, 0},
        // alternating bit patterns on every field
        '{21845, 43690, 85, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{43690, 21845, 170, 1'b1, 1'b0, 0, 0, 0, 0, 0},
        // zero bursts at the latest arrival
        '{65535, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0},
        '{65535, 0, 0, 1'b1, 1'b0, 0, 0, 0, 0, 0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;

    // Predictor copy of the loaded set.
    logic [ARR_W-1:0]      job_arrival [MAX_JOBS];
    logic [BURST_W-1:0]    job_burst   [MAX_JOBS];
    logic [PRIO_W-1:0]     job_prio    [MAX_JOBS];
    int                    job_count;

    sched_report_t         pending_reports [$];
    logic                  typed_beat;
    sched_report_t         typed_report;
    int                    mismatch_count;
    int                    cycle_count;

    nonpreemptive_priority_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run the loaded set to the end and queue one result per process in load order.
    task automatic plan_schedule();
        int            sched_clock;
        int            finished;
        int            pick;
        int            next_arr;
        int            turn;
        int            waiting;
        int            sum_wait;
        int            sum_turn;
        bit            found;
        bit            any;
        bit            done_mark [MAX_JOBS];
        int            comp [MAX_JOBS];
        sched_report_t rep;
        sched_clock = 0;
        finished    = 0;
        sum_wait    = 0;
        sum_turn    = 0;
        for (int i = 0; i < MAX_JOBS; i++) done_mark[i] = 1'b0;
        while (finished < job_count) begin
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < job_count; i++) begin
                if (done_mark[i] || int'(job_arrival[i]) > sched_clock) continue;
                if (!found || job_prio[i] < job_prio[pick] ||
                    (job_prio[i] == job_prio[pick] &&
                     job_arrival[i] < job_arrival[pick])) begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            if (found) begin
                sched_clock = sched_clock + int'(job_burst[pick]);
                if (sched_clock > int'(TIME_MAX)) sched_clock = int'(TIME_MAX);
                comp[pick]      = sched_clock;
                done_mark[pick] = 1'b1;
                finished++;
            end else begin
                // idle: jump to the earliest pending arrival
                any      = 1'b0;
                next_arr = 0;
                for (int i = 0; i < job_count; i++) begin
                    if (!done_mark[i] && (!any || int'(job_arrival[i]) < next_arr)) begin
                        next_arr = int'(job_arrival[i]);
                        any      = 1'b1;
                    end
                end
                sched_clock = next_arr;
            end
        end
        for (int k = 0; k < job_count; k++) begin
            turn    = comp[k] - int'(job_arrival[k]);
            waiting = (turn >= int'(job_burst[k])) ? turn - int'(job_burst[k]) : 0;
            sum_wait = sum_wait + waiting;
            if (sum_wait > int'(SUM_MAX)) sum_wait = int'(SUM_MAX);
            sum_turn = sum_turn + turn;
            if (sum_turn > int'(SUM_MAX)) sum_turn = int'(SUM_MAX);
            rep          = '0;
            rep.pnum     = PNUM_W'(k + 1);
            rep.comp     = TIME_W'(comp[k]);
            rep.turn     = TIME_W'(turn);
            rep.waiting  = TIME_W'(waiting);
            if (k == job_count - 1) begin
                rep.sum_wait = SUM_W'(sum_wait);
                rep.sum_turn = SUM_W'(sum_turn);
                rep.last     = 1'b1;
            end
            pending_reports.push_back(rep);
        end
        job_count = 0;
    endtask

    // Capture every accepted input beat; the last-marked or store-filling beat
    // triggers the prediction for the whole set.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            job_arrival[job_count] = s_tdata[ARR_W-1:0];
            job_burst[job_count]   = s_tdata[ARR_W +: BURST_W];
            job_prio[job_count]    = s_tdata[ARR_W+BURST_W +: PRIO_W];
            job_count++;
            if (typed_beat) begin
                pending_reports.push_back(typed_report);
                job_count = 0;
            end else if (s_tlast || job_count == MAX_JOBS) begin
                plan_schedule();
            end
        end
    end

    task automatic compare_field(input string name, input int pnum, input longint exp_v,
                                 input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: process %0d %s expected %0d actual %0d",
                     $time, pnum, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Check every accepted result beat against the oldest expectation.
    always @(posedge aclk) begin
        sched_report_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result beat with nothing expected, process %0d",
                         $time, m_tdata[PNUM_LSB +: PNUM_W]);
                mismatch_count++;
            end else begin
                exp_r = pending_reports.pop_front();
                compare_field("process_number", int'(exp_r.pnum), longint'(exp_r.pnum),
                              longint'(m_tdata[PNUM_LSB +: PNUM_W]));
                compare_field("completion_time", int'(exp_r.pnum), longint'(exp_r.comp),
                              longint'(m_tdata[COMP_LSB +: TIME_W]));
                compare_field("turnaround_time", int'(exp_r.pnum), longint'(exp_r.turn),
                              longint'(m_tdata[TURN_LSB +: TIME_W]));
                compare_field("waiting_time", int'(exp_r.pnum), longint'(exp_r.waiting),
                              longint'(m_tdata[WAIT_LSB +: TIME_W]));
                compare_field("sum_waiting", int'(exp_r.pnum), longint'(exp_r.sum_wait),
                              longint'(m_tdata[SUMW_LSB +: SUM_W]));
                compare_field("sum_turnaround", int'(exp_r.pnum), longint'(exp_r.sum_turn),
                              longint'(m_tdata[SUMT_LSB +: SUM_W]));
                compare_field("last_result", int'(exp_r.pnum), longint'(exp_r.last),
                              longint'(m_tlast));
            end
        end
    end

    // Hard stop for a hung block.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sink backpressure: ready runs, mostly short stalls, a few long ones, and
    // now and then a long stretch with no stall at all.
    initial begin
        int run_len;
        int stall_len;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            run_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 6);
            stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(1, 3);
            @(negedge aclk);
            m_tready <= 1'b1;
            repeat (run_len - 1) @(negedge aclk);
            @(negedge aclk);
            m_tready <= 1'b0;
            repeat (stall_len - 1) @(negedge aclk);
        end
    end

    // Present one process beat and hold it until the block takes it.
    task automatic drive_job(input int arr, input int bur, input int pr, input bit lst,
                             input bit typed, input sched_report_t rep);
        @(negedge aclk);
        s_tdata      <= {PRIO_W'(pr), BURST_W'(bur), ARR_W'(arr)};
        s_tlast      <= lst;
        s_tvalid     <= 1'b1;
        typed_beat   <= typed;
        typed_report <= rep;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid for the given number of cycles; zero keeps the stream back to back.
    task automatic idle_source(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 19);
        if (quiet || r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly small values so that priorities and arrivals collide often.
    function automatic int pick_value(input int narrow_hi, input int full_hi);
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, full_hi);
        return $urandom_range(0, narrow_hi);
    endfunction

    initial begin
        sched_report_t rep;
        int            jobs_sent;
        int            set_size;
        bit            quiet;
        bit            lst;
        aresetn        = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        s_tvalid       = 1'b0;
        typed_beat     = 1'b0;
        typed_report   = '0;
        job_count      = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table.
        for (int r = 0; r < NUM_ROWS; r++) begin
            rep          = '0;
            rep.pnum     = PNUM_W'(1);
            rep.comp     = TIME_W'(directed_rows[r].comp);
            rep.turn     = TIME_W'(directed_rows[r].turn);
            rep.waiting  = TIME_W'(directed_rows[r].waiting);
            rep.sum_wait = SUM_W'(directed_rows[r].sum_wait);
            rep.sum_turn = SUM_W'(directed_rows[r].sum_turn);
            rep.last     = 1'b1;
            drive_job(directed_rows[r].arrival, directed_rows[r].burst,
                      directed_rows[r].prio, directed_rows[r].last,
                      directed_rows[r].typed, rep);
            idle_source(pick_gap(1'b0));
        end

        // Random sets. Open with a full store whose last beat carries tlast only at random,
        // then mostly small sets with the occasional full one.
        jobs_sent = 0;
        rep       = '0;
        set_size  = MAX_JOBS;
        while (jobs_sent < RANDOM_JOBS) begin
            quiet = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < set_size; j++) begin
                if (set_size == MAX_JOBS)
                    lst = (j == set_size - 1) && (jobs_sent != 0) && $urandom_range(0, 1);
                else
                    lst = (j == set_size - 1);
                drive_job(pick_value(300, 65535), pick_value(300, 65535),
                          pick_value(3, 255), lst, 1'b0, rep);
                idle_source(pick_gap(quiet));
                jobs_sent++;
            end
            set_size = ($urandom_range(0, 9) == 0) ? MAX_JOBS : $urandom_range(1, 6);
        end

        @(negedge aclk);
        s_tvalid   <= 1'b0;
        typed_beat <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/npps_pkg.sv
hw/rtl/npps_cell.sv
hw/rtl/npps_pick.sv
hw/rtl/npps_report.sv
hw/rtl/nonpreemptive_priority_scheduler.sv
hw/rtl/npps_checker.sv
tb/sv/tb.sv
